### hdl/orthonormal_basis_gen_core_assert.svh
// Assertion macros shared by the basis generator modules.
// Each expects a clock aclk and an active-low reset aresetn in scope.
`ifndef ORTHONORMAL_BASIS_GEN_CORE_ASSERT_SVH
`define ORTHONORMAL_BASIS_GEN_CORE_ASSERT_SVH

// condition must hold at every edge out of reset
`define OBG_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define OBG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/obg_pkg.sv
package obg_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int W_W         = 32;                  // w and n components
    localparam int UV_W        = 18;                  // u and v components
    localparam int THR_W       = 16;
    localparam int SQ_W        = 2 * W_W;             // sum of squares
    localparam int ROOT_W      = W_W;                 // lengths
    localparam int Q_W         = FRAC_BITS + 1;       // quotient magnitude
    localparam int DVD_W       = W_W + FRAC_BITS;     // dividend magnitude
    localparam int PROD_W      = 2 * W_W;
    localparam int SQRT_CNT_W  = $clog2(ROOT_W);
    localparam int DIV_CNT_W   = $clog2(Q_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int S_TDATA_W   = ((3 * W_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = 6 * UV_W + 3 * W_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam longint FIX_ONE = 64'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic                  w_is_unit;
        logic signed [W_W-1:0] w_z;
        logic signed [W_W-1:0] w_y;
        logic signed [W_W-1:0] w_x;
    } obg_item_t;

    typedef struct packed {
        logic signed [UV_W-1:0] u_x;
        logic signed [UV_W-1:0] u_y;
        logic signed [UV_W-1:0] u_z;
        logic signed [UV_W-1:0] v_x;
        logic signed [UV_W-1:0] v_y;
        logic signed [UV_W-1:0] v_z;
        logic signed [W_W-1:0]  n_x;
        logic signed [W_W-1:0]  n_y;
        logic signed [W_W-1:0]  n_z;
        logic                   degenerate;
    } obg_result_t;

    localparam int RES_W = $bits(obg_result_t);

    // magnitude of a two's complement word; the most negative value maps to 2^(W-1)
    function automatic logic [W_W-1:0] obg_mag(input logic [W_W-1:0] a);
        return a[W_W-1] ? (~a + 1'b1) : a;
    endfunction

endpackage

### hdl/obg_fifo.sv
module obg_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  obg_pkg::obg_item_t   push_item,
    output logic                 full,
    input  logic                 pop,
    output obg_pkg::obg_item_t   pop_item,
    output logic                 empty
);

    `include "orthonormal_basis_gen_core_assert.svh"

    obg_pkg::obg_item_t             mem_reg [obg_pkg::QUEUE_DEPTH];
    logic [obg_pkg::PTR_W-1:0]      wr_ptr_reg;
    logic [obg_pkg::PTR_W-1:0]      rd_ptr_reg;
    logic [obg_pkg::PTR_W:0]        count_reg;

    assign full     = (count_reg == (obg_pkg::PTR_W+1)'(obg_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `OBG_ASSERT_ALWAYS(a_fifo_count, count_reg <= (obg_pkg::PTR_W+1)'(obg_pkg::QUEUE_DEPTH), "queue overfilled")

endmodule

### hdl/obg_sqrt.sv
module obg_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [obg_pkg::SQ_W-1:0]      radicand,
    output logic                          done,
    output logic [obg_pkg::ROOT_W-1:0]    root
);

    // one result bit per cycle, restoring digit recurrence
    logic                              busy_reg;
    logic                              done_reg;
    logic [obg_pkg::SQRT_CNT_W-1:0]    cnt_reg;
    logic [obg_pkg::SQ_W-1:0]          s_reg;
    logic [obg_pkg::ROOT_W:0]          rem_reg;
    logic [obg_pkg::ROOT_W-1:0]        root_reg;
    logic [obg_pkg::ROOT_W+2:0]        rem_sh;
    logic [obg_pkg::ROOT_W+2:0]        trial;

    assign rem_sh = {rem_reg, s_reg[obg_pkg::SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= obg_pkg::SQRT_CNT_W'(obg_pkg::ROOT_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            s_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            s_reg <= {s_reg[obg_pkg::SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= (obg_pkg::ROOT_W+1)'(rem_sh - trial);
                root_reg <= {root_reg[obg_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[obg_pkg::ROOT_W:0];
                root_reg <= {root_reg[obg_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

### hdl/obg_div.sv
module obg_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [obg_pkg::W_W-1:0]           mag,
    input  logic                              neg,
    input  logic [obg_pkg::ROOT_W-1:0]        divisor,
    output logic                              done,
    output logic signed [obg_pkg::UV_W-1:0]   quot
);

    `include "orthonormal_basis_gen_core_assert.svh"

    // mag * 2^F / divisor, one quotient bit per cycle; the divisor is never
    // below mag, so the quotient fits in F+1 bits
    logic                              busy_reg;
    logic                              done_reg;
    logic [obg_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [obg_pkg::DVD_W-1:0]         rem_reg;
    logic [obg_pkg::DVD_W-1:0]         dsh_reg;
    logic [obg_pkg::Q_W-1:0]           q_reg;
    logic                              neg_reg;
    logic signed [obg_pkg::UV_W-1:0]   q_ext;

    assign q_ext = obg_pkg::UV_W'(q_reg);
    assign quot  = neg_reg ? -q_ext : q_ext;
    assign done  = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= obg_pkg::DIV_CNT_W'(obg_pkg::Q_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {mag, obg_pkg::FRAC_BITS'(0)};
            dsh_reg <= {divisor, obg_pkg::FRAC_BITS'(0)};
            q_reg   <= '0;
            neg_reg <= neg;
        end else if (busy_reg) begin
            dsh_reg <= dsh_reg >> 1;
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[obg_pkg::Q_W-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[obg_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    `OBG_ASSERT_IMPL(a_div_range, done_reg, (quot <= obg_pkg::UV_W'(obg_pkg::FIX_ONE)) && (quot >= -obg_pkg::UV_W'(obg_pkg::FIX_ONE)), "quotient beyond unit range")

endmodule

### hdl/obg_front.sv
module obg_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [obg_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    output logic                                push,
    output obg_pkg::obg_item_t                  push_item,
    input  logic                                q_full
);

    // one-entry holding stage in front of the queue; takes a request every cycle while the queue is not full
    logic               hold_valid_reg;
    obg_pkg::obg_item_t hold_item_reg;

    assign s_tready  = !hold_valid_reg || !q_full;
    assign push      = hold_valid_reg && !q_full;
    assign push_item = hold_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            hold_valid_reg <= 1'b1;
        end else if (push) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hold_item_reg.w_x       <= s_tdata[obg_pkg::W_W-1:0];
            hold_item_reg.w_y       <= s_tdata[2*obg_pkg::W_W-1:obg_pkg::W_W];
            hold_item_reg.w_z       <= s_tdata[3*obg_pkg::W_W-1:2*obg_pkg::W_W];
            hold_item_reg.w_is_unit <= s_tuser;
        end
    end

endmodule

### hdl/obg_back.sv
module obg_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [obg_pkg::THR_W-1:0]         zero_threshold,
    input  logic                              q_empty,
    input  obg_pkg::obg_item_t                q_item,
    output logic                              q_pop,
    output logic                              res_valid,
    input  logic                              res_ready,
    output obg_pkg::obg_result_t              res
);

    `include "orthonormal_basis_gen_core_assert.svh"

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SQ    = 10'b0000000010,
        ST_ROOT  = 10'b0000000100,
        ST_NORM  = 10'b0000001000,
        ST_PICK  = 10'b0000010000,
        ST_SQ2   = 10'b0000100000,
        ST_ROOT2 = 10'b0001000000,
        ST_UDIV  = 10'b0010000000,
        ST_VMUL  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } obg_state_t;

    obg_state_t                           state_reg;
    logic [2:0]                           cnt_reg;
    logic                                 deg_reg;
    logic                                 br_y_reg;
    logic                                 sqrt_start_reg;
    logic                                 div_start_reg;
    logic                                 res_valid_reg;
    obg_pkg::obg_result_t                 res_reg;
    logic signed [obg_pkg::W_W-1:0]       n_x_reg, n_y_reg, n_z_reg;
    logic signed [obg_pkg::UV_W-1:0]      u_x_reg, u_y_reg, u_z_reg;
    logic [obg_pkg::SQ_W-1:0]             acc_reg;
    logic [obg_pkg::ROOT_W-1:0]           len_reg;
    logic [obg_pkg::PROD_W-1:0]           prod_reg;
    logic                                 prod_neg_reg;
    logic signed [obg_pkg::PROD_W-1:0]    p_reg [4];

    logic [obg_pkg::W_W-1:0]              mul_a, mul_b;
    logic                                 mul_neg;
    logic signed [obg_pkg::UV_W-1:0]      u_op;
    logic signed [obg_pkg::W_W-1:0]       n_op;
    logic signed [obg_pkg::PROD_W-1:0]    prod_s;
    logic signed [obg_pkg::PROD_W-1:0]    vx_sum, vy_sum, vz_sum;
    logic                                 pass2;
    logic                                 sqrt_done;
    logic [obg_pkg::ROOT_W-1:0]           sqrt_root;
    logic [2:0]                           div_done;
    logic signed [obg_pkg::UV_W-1:0]      q0, q1, q2;
    logic [obg_pkg::W_W-1:0]              d0_mag, d1_mag;
    logic                                 d0_neg, d1_neg;
    logic                                 out_load;
    obg_pkg::obg_result_t                 res_new;

    function automatic logic [obg_pkg::W_W-1:0] umag(input logic signed [obg_pkg::UV_W-1:0] u);
        logic [obg_pkg::UV_W-1:0] m;
        m = u[obg_pkg::UV_W-1] ? -u : u;
        return obg_pkg::W_W'(m);
    endfunction

    // divide by 2^F toward zero, then clamp to +-1
    function automatic logic signed [obg_pkg::UV_W-1:0] scale_sat(
        input logic signed [obg_pkg::PROD_W-1:0] x);
        logic signed [obg_pkg::PROD_W-1:0] b;
        logic signed [obg_pkg::PROD_W-1:0] r;
        b = x[obg_pkg::PROD_W-1] ? x + (obg_pkg::FIX_ONE - 1) : x;
        r = b >>> obg_pkg::FRAC_BITS;
        if (r > obg_pkg::FIX_ONE) begin
            return obg_pkg::UV_W'(obg_pkg::FIX_ONE);
        end
        if (r < -obg_pkg::FIX_ONE) begin
            return -obg_pkg::UV_W'(obg_pkg::FIX_ONE);
        end
        return obg_pkg::UV_W'(r);
    endfunction

    assign pass2     = (state_reg == ST_UDIV);
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign out_load  = (state_reg == ST_OUT) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign prod_s    = prod_neg_reg ? -$signed(prod_reg) : $signed(prod_reg);

    // shared multiplier operand select
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        u_op    = cnt_reg[0] ? (br_y_reg ? u_y_reg : u_x_reg) : u_z_reg;
        unique case (cnt_reg)
            3'd0:    n_op = n_y_reg;
            3'd1:    n_op = n_z_reg;
            3'd2:    n_op = n_x_reg;
            3'd3:    n_op = br_y_reg ? n_x_reg : n_y_reg;
            default: n_op = n_y_reg;
        endcase
        if (state_reg == ST_SQ) begin
            unique case (cnt_reg)
                3'd0:    mul_a = obg_pkg::obg_mag(n_x_reg);
                3'd1:    mul_a = obg_pkg::obg_mag(n_y_reg);
                3'd2:    mul_a = obg_pkg::obg_mag(n_z_reg);
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end else if (state_reg == ST_SQ2) begin
            unique case (cnt_reg)
                3'd0:    mul_a = obg_pkg::obg_mag(br_y_reg ? n_y_reg : n_x_reg);
                3'd1:    mul_a = obg_pkg::obg_mag(n_z_reg);
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end else if (state_reg == ST_VMUL) begin
            mul_a   = umag(u_op);
            mul_b   = obg_pkg::obg_mag(n_op);
            mul_neg = u_op[obg_pkg::UV_W-1] ^ n_op[obg_pkg::W_W-1];
        end
    end

    // divider operands: normalise pass uses n_x, n_y, n_z; u pass per branch
    always_comb begin
        if (pass2) begin
            d0_mag = obg_pkg::obg_mag(n_z_reg);
            d0_neg = br_y_reg ? n_z_reg[obg_pkg::W_W-1] : ~n_z_reg[obg_pkg::W_W-1];
            d1_mag = obg_pkg::obg_mag(br_y_reg ? n_y_reg : n_x_reg);
            d1_neg = br_y_reg ? ~n_y_reg[obg_pkg::W_W-1] : n_x_reg[obg_pkg::W_W-1];
        end else begin
            d0_mag = obg_pkg::obg_mag(n_x_reg);
            d0_neg = n_x_reg[obg_pkg::W_W-1];
            d1_mag = obg_pkg::obg_mag(n_y_reg);
            d1_neg = n_y_reg[obg_pkg::W_W-1];
        end
    end

    always_comb begin
        vx_sum = br_y_reg ? p_reg[0] - p_reg[1] : p_reg[0];
        vy_sum = br_y_reg ? -p_reg[2] : p_reg[1] - p_reg[2];
        vz_sum = br_y_reg ? p_reg[3] : -p_reg[3];
        res_new = '0;
        if (deg_reg) begin
            res_new.degenerate = 1'b1;
        end else begin
            res_new.u_x = u_x_reg;
            res_new.u_y = u_y_reg;
            res_new.u_z = u_z_reg;
            res_new.v_x = scale_sat(vx_sum);
            res_new.v_y = scale_sat(vy_sum);
            res_new.v_z = scale_sat(vz_sum);
            res_new.n_x = n_x_reg;
            res_new.n_y = n_y_reg;
            res_new.n_z = n_z_reg;
        end
    end

    obg_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start_reg),
        .radicand (acc_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    obg_div u_div0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .mag     (d0_mag),
        .neg     (d0_neg),
        .divisor (len_reg),
        .done    (div_done[0]),
        .quot    (q0)
    );

    obg_div u_div1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .mag     (d1_mag),
        .neg     (d1_neg),
        .divisor (len_reg),
        .done    (div_done[1]),
        .quot    (q1)
    );

    obg_div u_div2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg && !pass2),
        .mag     (obg_pkg::obg_mag(n_z_reg)),
        .neg     (n_z_reg[obg_pkg::W_W-1]),
        .divisor (len_reg),
        .done    (div_done[2]),
        .quot    (q2)
    );

    always_ff @(posedge aclk) begin
        prod_reg     <= mul_a * mul_b;
        prod_neg_reg <= mul_neg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            deg_reg        <= 1'b0;
            br_y_reg       <= 1'b0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            if (out_load) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    deg_reg <= 1'b0;
                    cnt_reg <= '0;
                    if (!q_empty) begin
                        n_x_reg   <= q_item.w_x;
                        n_y_reg   <= q_item.w_y;
                        n_z_reg   <= q_item.w_z;
                        acc_reg   <= '0;
                        state_reg <= q_item.w_is_unit ? ST_PICK : ST_SQ;
                    end
                end
                ST_SQ: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    if (cnt_reg == 3'd3) begin
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sqrt_done) begin
                        len_reg <= sqrt_root;
                        if (sqrt_root <= obg_pkg::ROOT_W'(zero_threshold)) begin
                            deg_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    if (div_done[0]) begin
                        n_x_reg   <= obg_pkg::W_W'(q0);
                        n_y_reg   <= obg_pkg::W_W'(q1);
                        n_z_reg   <= obg_pkg::W_W'(q2);
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    br_y_reg  <= obg_pkg::obg_mag(n_y_reg) > obg_pkg::obg_mag(n_x_reg);
                    cnt_reg   <= '0;
                    acc_reg   <= '0;
                    state_reg <= ST_SQ2;
                end
                ST_SQ2: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    if (cnt_reg == 3'd2) begin
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_ROOT2;
                    end
                end
                ST_ROOT2: begin
                    if (sqrt_done) begin
                        len_reg <= sqrt_root;
                        if (sqrt_root == '0) begin
                            deg_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_UDIV;
                        end
                    end
                end
                ST_UDIV: begin
                    if (div_done[0]) begin
                        u_x_reg   <= br_y_reg ? '0 : q0;
                        u_y_reg   <= br_y_reg ? q0 : '0;
                        u_z_reg   <= q1;
                        cnt_reg   <= '0;
                        state_reg <= ST_VMUL;
                    end
                end
                ST_VMUL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg != '0) begin
                        p_reg[2'(cnt_reg - 3'd1)] <= prod_s;
                    end
                    if (cnt_reg == 3'd4) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        res_reg   <= res_new;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `OBG_ASSERT_IMPL(a_deg_zero, res_valid_reg && res_reg.degenerate, res_reg[obg_pkg::RES_W-1:1] == '0, "degenerate result carries data")
    `OBG_ASSERT_IMPL(a_pop_idle, q_pop, !sqrt_start_reg && !div_start_reg, "new vector taken while a unit starts")

endmodule

### hdl/orthonormal_basis_gen_core.sv
// Orthonormal basis generator: for each vector w (signed Q16.16) the core
// returns n (w normalised, or w as given when the unit flag is set), a unit
// vector u perpendicular to n with a zero in the x or y slot, and v = n x u,
// all truncated toward zero. A vector whose length is at or below
// zero_threshold (normalising mode) or whose chosen 2-D length is zero comes
// back flagged degenerate with every other field zero. Vectors are taken into
// a two-deep queue at one request per clock while it has room; the back end
// works on one vector at a time, passing it through the shared bit-serial
// square root and the bit-serial dividers twice, or once with the unit flag
// set; degenerate vectors stop early. A finished result waits in the output
// register while the next vector is already under way. The user must write
// zero_threshold only while idle; the core itself does not enforce it.
module orthonormal_basis_gen_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: zero_threshold, unsigned Q0.16
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [obg_pkg::THR_W-1:0]           cfg_data,
    // input requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [obg_pkg::S_TDATA_W-1:0]       s_tdata,   // w_x, w_y, w_z
    input  logic                                s_tuser,   // w_is_unit
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [obg_pkg::M_TDATA_W-1:0]       m_tdata,   // u_x, u_y, u_z, v_x, v_y, v_z,
                                                           // n_x, n_y, n_z, zero pad
    output logic                                m_tuser    // degenerate
);

    logic [obg_pkg::THR_W-1:0] thr_reg;
    logic                      q_push, q_full, q_pop, q_empty;
    obg_pkg::obg_item_t        push_item, pop_item;
    obg_pkg::obg_result_t      res;

    // threshold register: always ready, idle-only writes by contract
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // front: take requests, unpack into queue entries
    obg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (q_push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    obg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // back: normalise, pick axis, build u and v
    obg_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .zero_threshold (thr_reg),
        .q_empty        (q_empty),
        .q_item         (pop_item),
        .q_pop          (q_pop),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res            (res)
    );

    // pack result, first field in the lowest bits
    assign m_tdata = obg_pkg::M_TDATA_W'({res.n_z, res.n_y, res.n_x,
                                          res.v_z, res.v_y, res.v_x,
                                          res.u_z, res.u_y, res.u_x});
    assign m_tuser = res.degenerate;

endmodule

### tb/tb_orthonormal_basis_gen_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the orthonormal basis generator.
// A directed table of vectors is walked first, then randomised vectors in
// several threshold phases; each accepted request is predicted independently
// or taken from its typed row, then compared field by field with the result.
module tb_orthonormal_basis_gen_core;
    import obg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 200;   // one full back-end pass plus margin

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [THR_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // w_x, w_y, w_z
    logic                 s_tuser;     // w_is_unit
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // u_x..v_z, n_x..n_z, pad
    logic                 m_tuser;     // degenerate

    orthonormal_basis_gen_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // bench copy of the threshold register
    logic [THR_W-1:0] thr_shadow;
    obg_result_t      basis_expected[$];
    int               err_count;
    int               n_requests;
    int               n_results;
    int               n_degenerate;
    int               n_cfg_writes;
    bit               idle_en;
    int               quiet_cycles;

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------
    function automatic longint unsigned root_floor(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // exact product, rescaled with truncation, clamped to +-1.0
    function automatic longint rescale_clamp(input longint p);
        longint r;
        r = p / FIX_ONE;
        if (r > FIX_ONE) r = FIX_ONE;
        if (r < -FIX_ONE) r = -FIX_ONE;
        return r;
    endfunction

    function automatic obg_result_t predict_basis(input logic signed [W_W-1:0] wx,
                                                  input logic signed [W_W-1:0] wy,
                                                  input logic signed [W_W-1:0] wz,
                                                  input logic unit,
                                                  input logic [THR_W-1:0] thr);
        obg_result_t r;
        longint nx, ny, nz, ux, uy, uz, vx, vy, vz, len, l2;
        longint unsigned ssq;
        r = '0;
        nx = wx;
        ny = wy;
        nz = wz;
        if (!unit) begin
            ssq = longint'(nx * nx) + longint'(ny * ny) + longint'(nz * nz);
            len = longint'(root_floor(ssq));
            if (len <= longint'(thr) || len == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            nx = (nx * FIX_ONE) / len;
            ny = (ny * FIX_ONE) / len;
            nz = (nz * FIX_ONE) / len;
        end
        if ((ny < 0 ? -ny : ny) > (nx < 0 ? -nx : nx)) begin
            l2 = longint'(root_floor(ny * ny + nz * nz));
            if (l2 == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            ux = 0;
            uy = (nz * FIX_ONE) / l2;
            uz = (-ny * FIX_ONE) / l2;
            vx = rescale_clamp(uz * ny - nz * uy);
            vy = rescale_clamp(-nx * uz);
            vz = rescale_clamp(uy * nx);
        end else begin
            l2 = longint'(root_floor(nx * nx + nz * nz));
            if (l2 == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            ux = (-nz * FIX_ONE) / l2;
            uy = 0;
            uz = (nx * FIX_ONE) / l2;
            vx = rescale_clamp(uz * ny);
            vy = rescale_clamp(nz * ux - uz * nx);
            vz = rescale_clamp(-ny * ux);
        end
        r.u_x = ux[UV_W-1:0];
        r.u_y = uy[UV_W-1:0];
        r.u_z = uz[UV_W-1:0];
        r.v_x = vx[UV_W-1:0];
        r.v_y = vy[UV_W-1:0];
        r.v_z = vz[UV_W-1:0];
        r.n_x = nx[W_W-1:0];
        r.n_y = ny[W_W-1:0];
        r.n_z = nz[W_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic compare_field(input string what, input longint got, input longint want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    function automatic obg_result_t unpack_result(input logic [M_TDATA_W-1:0] d,
                                                  input logic deg);
        obg_result_t r;
        r.u_x        = d[0*UV_W +: UV_W];
        r.u_y        = d[1*UV_W +: UV_W];
        r.u_z        = d[2*UV_W +: UV_W];
        r.v_x        = d[3*UV_W +: UV_W];
        r.v_y        = d[4*UV_W +: UV_W];
        r.v_z        = d[5*UV_W +: UV_W];
        r.n_x        = d[6*UV_W +: W_W];
        r.n_y        = d[6*UV_W + W_W +: W_W];
        r.n_z        = d[6*UV_W + 2*W_W +: W_W];
        r.degenerate = deg;
        return r;
    endfunction

    // table rows with a typed result use it instead of the prediction
    bit          next_typed;
    obg_result_t next_typed_res;

    always @(posedge aclk) begin
        obg_result_t got;
        obg_result_t want;
        if (aresetn) begin
            // accepted request: queue its expectation
            if (s_tvalid && s_tready) begin
                n_requests++;
                if (next_typed) basis_expected.push_back(next_typed_res);
                else basis_expected.push_back(predict_basis(s_tdata[31:0], s_tdata[63:32],
                                                            s_tdata[95:64], s_tuser,
                                                            thr_shadow));
            end
            // accepted result: compare with the oldest expectation
            if (m_tvalid && m_tready) begin
                n_results++;
                got = unpack_result(m_tdata, m_tuser);
                if (m_tuser) n_degenerate++;
                if (basis_expected.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    want = basis_expected.pop_front();
                    compare_field("u_x", got.u_x, want.u_x);
                    compare_field("u_y", got.u_y, want.u_y);
                    compare_field("u_z", got.u_z, want.u_z);
                    compare_field("v_x", got.v_x, want.v_x);
                    compare_field("v_y", got.v_y, want.v_y);
                    compare_field("v_z", got.v_z, want.v_z);
                    compare_field("n_x", got.n_x, want.n_x);
                    compare_field("n_y", got.n_y, want.n_y);
                    compare_field("n_z", got.n_z, want.n_z);
                    compare_field("degenerate", got.degenerate, want.degenerate);
                    if (m_tdata[M_TDATA_W-1:M_FIELDS_W] != '0)
                        report_mismatch("pad", m_tdata[M_TDATA_W-1:M_FIELDS_W], 0);
                end
            end
        end
    end

    // watchdog: counts cycles with no handshake on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results pending", basis_expected.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // result side back-pressure in random bursts while idling is enabled
    int stall_left;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    // one request; s_tvalid stays high into the next call unless a gap is taken
    task automatic send_vector(input logic signed [W_W-1:0] wx, input logic signed [W_W-1:0] wy,
                               input logic signed [W_W-1:0] wz, input logic unit);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wz, wy, wx};
        s_tuser  <= unit;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // sender holds off until every result is back, then the threshold is written
    task automatic write_threshold(input logic [THR_W-1:0] thr);
        s_tvalid <= 1'b0;
        while (basis_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= thr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        thr_shadow = thr;
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [W_W-1:0] rand_component(input int span);
        logic signed [W_W-1:0] v;
        v = $urandom;
        return v >>> $urandom_range(W_W - 1 - span, W_W - 1);
    endfunction

    typedef struct {
        int                    thr;
        logic signed [W_W-1:0] x;
        logic signed [W_W-1:0] y;
        logic signed [W_W-1:0] z;
        logic                  unit;
        bit                    typed;
        obg_result_t           res;
    } stim_row_t;

    stim_row_t dir_rows[$];

    function automatic stim_row_t mk_row(input int thr, input longint x, input longint y,
                                         input longint z, input int unit,
                                         input int typed, input obg_result_t res);
        stim_row_t r;
        r.thr   = thr;
        r.x     = x[W_W-1:0];
        r.y     = y[W_W-1:0];
        r.z     = z[W_W-1:0];
        r.unit  = unit[0];
        r.typed = typed[0];
        r.res   = res;
        return r;
    endfunction

    initial begin
        obg_result_t deg_res;
        obg_result_t x_axis;
        obg_result_t none;
        logic signed [W_W-1:0] rx, ry, rz;
        logic ru;
        int kind;
        int phase;
        int k;

        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        thr_shadow = '0;
        idle_en    = 1'b1;
        next_typed = 1'b0;
        err_count  = 0;
        n_requests = 0;
        n_results  = 0;
        n_degenerate = 0;
        n_cfg_writes = 0;

        none    = '0;
        deg_res = '0;
        deg_res.degenerate = 1'b1;
        // n along +x: u = +z, v = -y
        x_axis     = '0;
        x_axis.n_x = 32'sd65536;
        x_axis.u_z = 18'sd65536;
        x_axis.v_y = -18'sd65536;

        // threshold 0 (reset value)
        dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 1, deg_res));
        dir_rows.push_back(mk_row(0, 0, 0, 0, 1, 1, deg_res));
        dir_rows.push_back(mk_row(0, 65536, 0, 0, 1, 1, x_axis));
        dir_rows.push_back(mk_row(0, 3 * 65536, 0, 0, 0, 1, x_axis));
        dir_rows.push_back(mk_row(0, 0, 65536, 0, 1, 0, none));
        dir_rows.push_back(mk_row(0, 0, 0, -65536, 1, 0, none));
        dir_rows.push_back(mk_row(0, -2147483648, -2147483648, -2147483648, 0, 0, none));
        dir_rows.push_back(mk_row(0, 2147483647, 2147483647, 2147483647, 1, 0, none));
        dir_rows.push_back(mk_row(0, -2147483648, 2147483647, -2147483648, 1, 0, none));
        dir_rows.push_back(mk_row(0, 1, 0, 0, 0, 0, none));
        dir_rows.push_back(mk_row(0, 1, 1, 1, 0, 0, none));
        dir_rows.push_back(mk_row(0, 0, -1, 0, 0, 0, none));
        dir_rows.push_back(mk_row(0, 123456, -789012, 345678, 0, 0, none));
        dir_rows.push_back(mk_row(0, -5, 7, -9, 1, 0, none));
        dir_rows.push_back(mk_row(0, 2147483647, 1, 0, 0, 0, none));
        // threshold at its top: a length equal to it is degenerate
        dir_rows.push_back(mk_row(65535, 65535, 0, 0, 0, 1, deg_res));
        dir_rows.push_back(mk_row(65535, 65536, 0, 0, 0, 1, x_axis));
        dir_rows.push_back(mk_row(65535, 0, 0, -65535, 0, 1, deg_res));
        dir_rows.push_back(mk_row(65535, 1000000, -3, 7, 0, 0, none));
        dir_rows.push_back(mk_row(65535, 3, 4, 0, 1, 0, none));
        dir_rows.push_back(mk_row(12345, 12345, 0, 0, 0, 1, deg_res));
        dir_rows.push_back(mk_row(12345, 0, 12346, 0, 0, 0, none));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table; the threshold is rewritten when a row asks for another
        foreach (dir_rows[i]) begin
            if (THR_W'(dir_rows[i].thr) != thr_shadow)
                write_threshold(THR_W'(dir_rows[i].thr));
            next_typed     = dir_rows[i].typed;
            next_typed_res = dir_rows[i].res;
            send_vector(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].unit);
        end
        next_typed = 1'b0;

        // random phases; the last one runs without idling on either side
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_threshold(THR_W'($urandom_range(0, 65535)));
                1: write_threshold(16'hFFFF);
                2: write_threshold(THR_W'($urandom_range(0, 4000)));
                default: begin
                    write_threshold(16'h0000);
                    idle_en = 1'b0;
                end
            endcase
            for (k = 0; k < 150; k++) begin
                kind = $urandom_range(0, 9);
                ru   = 1'b0;
                case (kind)
                    5, 6: begin
                        // roughly unit vectors straight into the basis stage
                        rx = $signed($urandom_range(0, 131072)) - 65536;
                        ry = $signed($urandom_range(0, 131072)) - 65536;
                        rz = $signed($urandom_range(0, 131072)) - 65536;
                        ru = 1'b1;
                    end
                    7: begin
                        rx = $urandom;
                        ry = $urandom;
                        rz = $urandom;
                        ru = 1'($urandom_range(0, 1));
                    end
                    8: begin
                        // short vectors around the threshold
                        rx = rand_component(17);
                        ry = rand_component(15);
                        rz = rand_component(16);
                    end
                    9: begin
                        rx = $urandom_range(0, 1) ? rand_component(31) : '0;
                        ry = $urandom_range(0, 1) ? rand_component(31) : '0;
                        rz = $urandom_range(0, 1) ? rand_component(31) : '0;
                        ru = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        rx = rand_component(31);
                        ry = rand_component(31);
                        rz = rand_component(31);
                    end
                endcase
                send_vector(rx, ry, rz, ru);
            end
        end
        s_tvalid <= 1'b0;

        while (basis_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests, %0d results (%0d degenerate), %0d threshold writes",
                 n_requests, n_results, n_degenerate, n_cfg_writes);
        $display("including axis, extreme, zero-length and threshold-edge vectors");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/obg_pkg.sv
hdl/obg_fifo.sv
hdl/obg_sqrt.sv
hdl/obg_div.sv
hdl/obg_front.sv
hdl/obg_back.sv
hdl/orthonormal_basis_gen_core.sv
tb/tb_orthonormal_basis_gen_core.sv
